// File: rtl/core/epa_pkg.sv
// Shared types, constants and a helper function for the encoder parameter adjuster.
`timescale 1ns / 1ps

package epa_pkg;

  // Fixed limits and constants of the adjuster.
  localparam logic [13:0] FREQ_LIMIT      = 14'd10000;
  localparam logic [5:0]  AMP_LIMIT       = 6'd50;
  localparam logic [15:0] RELOAD_NUM      = 16'd50000;
  localparam logic [13:0] FREQ_RESET      = 14'd1000;
  localparam logic [15:0] RELOAD_RESET    = 16'd50;
  localparam int          DIV_STEPS       = 16;
  localparam int          DIV_CNT_W       = $clog2(DIV_STEPS);

  // Step size codes.
  localparam logic [1:0]  STEP_SEL_ONE      = 2'd0;
  localparam logic [1:0]  STEP_SEL_HUNDRED  = 2'd1;
  localparam logic [1:0]  STEP_SEL_THOUSAND = 2'd2;

  // Register map indices.
  typedef enum logic [1:0] {
    REG_FREQ_EN  = 2'd0,
    REG_AMP_EN   = 2'd1,
    REG_STEP_SEL = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       freq_en;
    logic       amp_en;
    logic [1:0] step_sel;
  } cfg_t;

  typedef struct packed {
    logic req_type;
    logic other_pin_level;
  } in_t;

  typedef struct packed {
    logic        step_taken;
    logic [13:0] frequency_value;
    logic [21:0] tuning_word;
    logic [15:0] timer_reload;
    logic [14:0] timer_compare;
    logic [5:0]  amplitude_value;
    logic [2:0]  amplitude_tens;
    logic [3:0]  amplitude_ones;
  } out_t;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
  } dp_sts_t;

  function automatic logic [9:0] step_size(input logic [1:0] sel);
    logic [9:0] s;
    begin
      unique case (sel)
        STEP_SEL_ONE:      s = 10'd1;
        STEP_SEL_HUNDRED:  s = 10'd100;
        STEP_SEL_THOUSAND: s = 10'd1000;
        default:           s = 10'd0;
      endcase
      return s;
    end
  endfunction

endpackage

// File: rtl/core/epa_ctrl.sv
// Controller state machine sequencing acceptance, reload division and result hand-off.
`timescale 1ns / 1ps

module epa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  epa_pkg::dp_sts_t  sts,
  output epa_pkg::dp_cmd_t  cmd
);

  epa_pkg::state_t state;
  epa_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= epa_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      epa_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = sts.need_div ? epa_pkg::ST_DIV : epa_pkg::ST_DONE;
        end
      end
      epa_pkg::ST_DIV: begin
        if (sts.div_last) begin
          state_next = epa_pkg::ST_DONE;
        end
      end
      epa_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = epa_pkg::ST_IDLE;
        end
      end
      default: state_next = epa_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      epa_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      epa_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      epa_pkg::ST_DONE: begin
        cmd.out_load = !out_valid || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// File: rtl/core/epa_dp.sv
// Datapath: stored settings, step arithmetic, iterative reload divider and output register.
`timescale 1ns / 1ps

module epa_dp (
  input  logic              clk,
  input  logic              rst,
  input  epa_pkg::cfg_t     cfg,
  input  epa_pkg::in_t      in_data,
  input  epa_pkg::dp_cmd_t  cmd,
  output epa_pkg::dp_sts_t  sts,
  output epa_pkg::out_t     out_data
);

  logic [13:0] freq;
  logic [5:0]  amp;
  logic [15:0] reload;
  logic        step_pend;

  logic [15:0] dvq;
  logic [13:0] dvr;
  logic [13:0] dvd;
  logic [epa_pkg::DIV_CNT_W-1:0] dcnt;

  logic [9:0]  step;
  logic        qual;
  logic        up;
  logic        freq_move;
  logic        f_up_ok;
  logic [13:0] freq_up;
  logic [13:0] f_cl;
  logic [13:0] freq_dn;
  logic [13:0] freq_next;
  logic [5:0]  amp_next;

  logic [14:0] trial;
  logic [14:0] diff;
  logic        ge;
  logic [13:0] rem_n;
  logic [15:0] q_n;

  logic [13:0] amp_x205;
  logic [2:0]  tens;
  logic [6:0]  tens_x10;
  logic [5:0]  ones_full;

  always_comb begin
    step      = epa_pkg::step_size(cfg.step_sel);
    qual      = !in_data.other_pin_level;
    up        = in_data.req_type;
    freq_move = qual && cfg.freq_en && (step != 10'd0);
    f_up_ok   = freq < epa_pkg::FREQ_LIMIT;
    freq_up   = freq + {4'd0, step};
    f_cl      = (freq > epa_pkg::FREQ_LIMIT - 14'd1) ? epa_pkg::FREQ_LIMIT : freq;
    freq_dn   = (f_cl > {4'd0, step}) ? (f_cl - {4'd0, step}) : 14'd0;

    freq_next = freq;
    if (freq_move) begin
      if (up) begin
        if (f_up_ok) begin
          freq_next = freq_up;
        end
      end else begin
        freq_next = freq_dn;
      end
    end

    amp_next = amp;
    if (qual && cfg.amp_en) begin
      if (up) begin
        if (amp < epa_pkg::AMP_LIMIT) begin
          amp_next = amp + 6'd1;
        end
      end else if (amp != 6'd0) begin
        amp_next = amp - 6'd1;
      end
    end

    sts.need_div = freq_move && up && f_up_ok;
    sts.div_last = dcnt == epa_pkg::DIV_CNT_W'(epa_pkg::DIV_STEPS - 1);
  end

  // One restoring division step per cycle.
  always_comb begin
    trial = {dvr, dvq[15]};
    diff  = trial - {1'b0, dvd};
    ge    = trial >= {1'b0, dvd};
    rem_n = ge ? diff[13:0] : trial[13:0];
    q_n   = {dvq[14:0], ge};
  end

  // Digit split by reciprocal multiply; exact for the whole six-bit range.
  always_comb begin
    amp_x205  = 14'(amp) * 14'd205;
    tens      = amp_x205[13:11];
    tens_x10  = 7'(tens) * 7'd10;
    ones_full = amp - tens_x10[5:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      freq      <= epa_pkg::FREQ_RESET;
      amp       <= 6'd0;
      reload    <= epa_pkg::RELOAD_RESET;
      step_pend <= 1'b0;
      dcnt      <= '0;
    end else begin
      if (cmd.accept) begin
        freq      <= freq_next;
        amp       <= amp_next;
        step_pend <= (freq_next != freq) || (amp_next != amp);
        dcnt      <= '0;
      end else if (cmd.div_step) begin
        dcnt <= dcnt + 1'b1;
        if (sts.div_last) begin
          reload <= q_n;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dvq <= epa_pkg::RELOAD_NUM;
      dvr <= 14'd0;
      dvd <= freq_up;
    end else if (cmd.div_step) begin
      dvq <= q_n;
      dvr <= rem_n;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.step_taken      <= step_pend;
      out_data.frequency_value <= freq;
      out_data.tuning_word     <= {freq, 8'd0};
      out_data.timer_reload    <= reload;
      out_data.timer_compare   <= reload[15:1];
      out_data.amplitude_value <= amp;
      out_data.amplitude_tens  <= tens;
      out_data.amplitude_ones  <= ones_full[3:0];
    end
  end

endmodule

// File: rtl/core/encoder_parameter_adjuster.sv
// Top level of the encoder parameter adjuster: register port, controller and datapath.
// An edge that raises the frequency passes through the restoring divider for the timer reload
// before its result is loaded into the output register; any other edge goes straight to the
// output register. One transaction is in work at a time, so a new edge is taken only once
// the previous result has been loaded into the output register, which stalls can delay.
// Reset (rst, synchronous, active high) sets frequency 1000, amplitude 0, reload 50.
`timescale 1ns / 1ps

module encoder_parameter_adjuster (
  input  logic           clk,
  input  logic           rst,
  // Configuration port.
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  // Encoder edge transactions.
  input  logic           in_valid,
  output logic           in_stall,
  input  epa_pkg::in_t   in_data,
  // Result transactions.
  output logic           out_valid,
  input  logic           out_stall,
  output epa_pkg::out_t  out_data
);

  epa_pkg::cfg_t    cfg;
  epa_pkg::dp_cmd_t cmd;
  epa_pkg::dp_sts_t sts;
  logic [1:0]       reg_idx;
  logic             cfg_wr;

  // The register port never inserts wait states. Registers sit on word
  // boundaries, so the low two address bits play no part in decoding.
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        epa_pkg::REG_FREQ_EN:  cfg.freq_en  <= pwdata[0];
        epa_pkg::REG_AMP_EN:   cfg.amp_en   <= pwdata[0];
        epa_pkg::REG_STEP_SEL: cfg.step_sel <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Reads return the stored register; the unused slot reads as zero.
  always_comb begin
    prdata = 32'd0;
    unique case (reg_idx)
      epa_pkg::REG_FREQ_EN:  prdata = {31'd0, cfg.freq_en};
      epa_pkg::REG_AMP_EN:   prdata = {31'd0, cfg.amp_en};
      epa_pkg::REG_STEP_SEL: prdata = {30'd0, cfg.step_sel};
      default:               prdata = 32'd0;
    endcase
  end

  // The controller accepts one transaction, runs the reload divider when the
  // frequency has been raised, and then hands the settings to the output
  // register, which holds the result while the consumer stalls.
  epa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath updates frequency and amplitude at acceptance, the reload after division,
  // and builds the result fields, including the digit split of the amplitude.
  epa_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the encoder parameter adjuster: edge transactions in, settings out.
`timescale 1ns / 1ps

module tb_top;

  // Limits and constants of the adjuster, kept here independently of the package so that a
  // wrong package value shows up as a mismatch rather than being copied into the prediction.
  localparam int unsigned FREQ_CAP        = 10000;
  localparam int unsigned AMP_CAP         = 50;
  localparam int unsigned RELOAD_DIVIDEND = 50000;
  localparam int unsigned FREQ_AT_RESET   = 1000;
  localparam int unsigned RELOAD_AT_RESET = 50;

  // Step select code with no step size behind it; the package names only the three real ones.
  localparam logic [1:0] STEP_SEL_NONE = 2'd3;

  // Encoder edge codes.
  localparam logic EDGE_DOWN = 1'b0;
  localparam logic EDGE_UP   = 1'b1;
  localparam logic PIN_LOW   = 1'b0;
  localparam logic PIN_HIGH  = 1'b1;

  localparam int RANDOM_EDGES = 1100;
  localparam int LONG_HOLD    = 300;
  localparam int TAIL_CYCLES  = 40;
  localparam int CYCLE_LIMIT  = 500000;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [3:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;
  logic          in_valid = 1'b0;
  logic          in_stall;
  epa_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  epa_pkg::out_t out_data;

  encoder_parameter_adjuster u_top (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  // Encoder edges waiting to be offered, and the settings that accepted edges must produce,
  // oldest first.
  epa_pkg::in_t  edge_backlog_q[$];
  epa_pkg::out_t settings_due_q[$];

  // Mirror of the configuration registers, as they stand after reset.
  logic       cfg_freq_en = 1'b0;
  logic       cfg_amp_en = 1'b0;
  logic [1:0] cfg_step = epa_pkg::STEP_SEL_ONE;

  // Predicted contents of the adjuster's stores.
  int unsigned freq_now = FREQ_AT_RESET;
  int unsigned amp_now = 0;
  int unsigned reload_now = RELOAD_AT_RESET;

  int errors = 0;
  int cycle_cnt = 0;

  // Traffic shaping, set per phase by the stimulus process.
  bit tx_gappy = 1'b0;
  bit rx_stall_on = 1'b0;
  bit pause_tx = 1'b0;
  int hold_reqs = 0;

  // Works out the settings after one encoder edge and advances the predicted stores.
  function automatic epa_pkg::out_t next_settings(epa_pkg::in_t ev);
    epa_pkg::out_t res;
    int unsigned   f;
    int unsigned   stp;
    int unsigned   was_f;
    int unsigned   was_a;
    was_f = freq_now;
    was_a = amp_now;
    // An edge counts only while the opposite pin is low.
    if (ev.other_pin_level == PIN_LOW) begin
      if (cfg_freq_en) begin
        case (cfg_step)
          epa_pkg::STEP_SEL_ONE:      stp = 1;
          epa_pkg::STEP_SEL_HUNDRED:  stp = 100;
          epa_pkg::STEP_SEL_THOUSAND: stp = 1000;
          default:                    stp = 0;
        endcase
        if (stp != 0) begin
          f = freq_now;
          if (ev.req_type == EDGE_UP) begin
            // Raising is refused at or above the cap; otherwise the reload is recomputed.
            if (f < FREQ_CAP) begin
              f = f + stp;
              reload_now = (RELOAD_DIVIDEND / f) & 32'hFFFF;
            end
          end else begin
            // Lowering clamps to the cap first and saturates at zero; the reload stays.
            if (f > FREQ_CAP) f = FREQ_CAP;
            f = (f > stp) ? f - stp : 0;
          end
          freq_now = f;
        end
      end
      if (cfg_amp_en) begin
        if (ev.req_type == EDGE_UP) begin
          if (amp_now < AMP_CAP) amp_now = amp_now + 1;
        end else if (amp_now > 0) begin
          amp_now = amp_now - 1;
        end
      end
    end
    res.step_taken      = (freq_now != was_f) || (amp_now != was_a);
    res.frequency_value = 14'(freq_now);
    res.tuning_word     = 22'(freq_now << 8);
    res.timer_reload    = 16'(reload_now);
    res.timer_compare   = 15'(reload_now >> 1);
    res.amplitude_value = 6'(amp_now);
    res.amplitude_tens  = 3'(amp_now / 10);
    res.amplitude_ones  = 4'(amp_now % 10);
    return res;
  endfunction

  function automatic void check_field(string fname, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
    end
  endfunction

  function automatic void post_edge(logic dir, logic pin);
    epa_pkg::in_t ev;
    ev.req_type = dir;
    ev.other_pin_level = pin;
    edge_backlog_q.push_back(ev);
  endfunction

  // ---------------------------------------------------------------------------------------
  // Input side. The acceptance of a transaction is seen at the rising edge, where the
  // prediction is made at once; the driver then reacts at the following falling edge.
  // ---------------------------------------------------------------------------------------
  logic edge_taken = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      edge_taken <= 1'b0;
    end else begin
      edge_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) settings_due_q.push_back(next_settings(in_data));
    end
  end

  // Driver: offers edges in bursts of random length, separated by random gaps while tx_gappy is
  // set. A payload on offer is held until it is taken, and valid is written once per step.
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin : edge_driver
    logic         nxt_valid;
    epa_pkg::in_t nxt_data;
    nxt_valid = in_valid;
    nxt_data = in_data;
    if (!rst) begin
      if (edge_taken) nxt_valid = 1'b0;
      if (!nxt_valid && !pause_tx && edge_backlog_q.size() != 0) begin
        if (gap_left != 0) begin
          gap_left--;
        end else begin
          nxt_data = edge_backlog_q.pop_front();
          nxt_valid = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left = tx_gappy ? $urandom_range(1, 25) : 0;
          end
        end
      end
    end
    in_valid <= nxt_valid;
    in_data <= nxt_data;
  end

  // ---------------------------------------------------------------------------------------
  // Output side. While rx_stall_on is set the receiver stalls by a 32-bit pattern that is
  // redrawn each time round, with a varying density. On request it holds off for a long
  // stretch, counted here, so that the adjuster fills up and has to stall its own input.
  // ---------------------------------------------------------------------------------------
  int          hold_left = 0;
  int          holds_served = 0;
  logic [31:0] stall_pat = '0;
  logic [4:0]  pat_bit = '0;

  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_served != hold_reqs) begin
      holds_served++;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else begin
      if (pat_bit == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pat = $urandom & $urandom;
          1:       stall_pat = $urandom;
          2:       stall_pat = $urandom | $urandom;
          default: stall_pat = '0;
        endcase
      end
      out_stall <= rx_stall_on && stall_pat[pat_bit];
      pat_bit = pat_bit + 1'b1;
    end
  end

  // Every accepted result is checked against the oldest outstanding prediction.
  always @(posedge clk) begin : result_check
    epa_pkg::out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (settings_due_q.size() == 0) begin
        errors++;
        $display("%0t: result with no edge outstanding, expected none, actual %h",
                 $time, out_data);
      end else begin
        want = settings_due_q.pop_front();
        check_field("step_taken", want.step_taken, out_data.step_taken);
        check_field("frequency_value", want.frequency_value, out_data.frequency_value);
        check_field("tuning_word", want.tuning_word, out_data.tuning_word);
        check_field("timer_reload", want.timer_reload, out_data.timer_reload);
        check_field("timer_compare", want.timer_compare, out_data.timer_compare);
        check_field("amplitude_value", want.amplitude_value, out_data.amplitude_value);
        check_field("amplitude_tens", want.amplitude_tens, out_data.amplitude_tens);
        check_field("amplitude_ones", want.amplitude_ones, out_data.amplitude_ones);
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Register writes: a setup phase, then an access phase held until pready is seen.
  // ---------------------------------------------------------------------------------------
  task automatic write_reg(epa_pkg::reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      epa_pkg::REG_FREQ_EN:  cfg_freq_en = val[0];
      epa_pkg::REG_AMP_EN:   cfg_amp_en = val[0];
      epa_pkg::REG_STEP_SEL: cfg_step = val[1:0];
      default:               ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Waits until the sender has nothing on offer and every predicted result has arrived.
  // While the sender is paused the backlog may still hold edges.
  task automatic drain();
    do @(posedge clk);
    while (in_valid || settings_due_q.size() != 0 ||
           (!pause_tx && edge_backlog_q.size() != 0));
  endtask

  // Every edge produces exactly one result, so an empty prediction store means the block
  // is idle and the registers may be rewritten.
  task automatic apply_setup(logic fe, logic ae, logic [1:0] ss);
    drain();
    write_reg(epa_pkg::REG_FREQ_EN, {31'b0, fe});
    write_reg(epa_pkg::REG_AMP_EN, {31'b0, ae});
    write_reg(epa_pkg::REG_STEP_SEL, {30'b0, ss});
  endtask

  initial begin : stimulus
    int         phase;
    int         qualified;
    int         budget;
    int         left;
    int         run;
    int         k;
    logic       dir;
    logic       pin;
    logic       fe;
    logic       ae;
    logic       noisy;
    logic [1:0] ss;
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed part. With nothing enabled no edge changes anything.
    post_edge(EDGE_DOWN, PIN_LOW);
    post_edge(EDGE_UP, PIN_LOW);
    post_edge(EDGE_DOWN, PIN_HIGH);
    post_edge(EDGE_UP, PIN_HIGH);
    // Both adjusts on but no step size: only the amplitude moves.
    apply_setup(1'b1, 1'b1, STEP_SEL_NONE);
    post_edge(EDGE_UP, PIN_LOW);
    post_edge(EDGE_DOWN, PIN_LOW);
    post_edge(EDGE_UP, PIN_HIGH);
    // From 1000 down by 1000 reaches zero exactly; the next decrement changes nothing.
    apply_setup(1'b1, 1'b0, epa_pkg::STEP_SEL_THOUSAND);
    post_edge(EDGE_DOWN, PIN_LOW);
    post_edge(EDGE_DOWN, PIN_LOW);
    // From zero up by one gives the largest reload and compare.
    apply_setup(1'b1, 1'b0, epa_pkg::STEP_SEL_ONE);
    post_edge(EDGE_UP, PIN_LOW);
    post_edge(EDGE_UP, PIN_LOW);
    // Step of a hundred with both values moving; a decrement below zero saturates.
    apply_setup(1'b1, 1'b1, epa_pkg::STEP_SEL_HUNDRED);
    post_edge(EDGE_UP, PIN_LOW);
    post_edge(EDGE_DOWN, PIN_LOW);
    post_edge(EDGE_DOWN, PIN_LOW);
    post_edge(EDGE_DOWN, PIN_HIGH);
    // Amplitude only, starting at its lower bound.
    apply_setup(1'b0, 1'b1, epa_pkg::STEP_SEL_ONE);
    post_edge(EDGE_DOWN, PIN_LOW);
    post_edge(EDGE_UP, PIN_LOW);

    // Random part, in phases of one register setting each.
    phase = 0;
    qualified = 0;
    while (qualified < RANDOM_EDGES) begin
      if (phase % 5 == 2) begin
        // Climb to the cap, step one below it, then jump past it and fall back through
        // the clamp. This reaches the top of the frequency range.
        ae = $urandom_range(0, 1);
        tx_gappy = $urandom_range(0, 1);
        rx_stall_on = $urandom_range(0, 1);
        apply_setup(1'b1, ae, epa_pkg::STEP_SEL_THOUSAND);
        repeat (12) post_edge(EDGE_UP, PIN_LOW);
        apply_setup(1'b1, ae, epa_pkg::STEP_SEL_ONE);
        post_edge(EDGE_DOWN, PIN_LOW);
        apply_setup(1'b1, ae, epa_pkg::STEP_SEL_THOUSAND);
        post_edge(EDGE_UP, PIN_LOW);
        post_edge(EDGE_UP, PIN_LOW);
        post_edge(EDGE_DOWN, PIN_LOW);
        post_edge(EDGE_DOWN, PIN_LOW);
        qualified += 17;
      end else begin
        if (phase == 0) begin
          fe = 1'b1;
          ae = 1'b1;
          ss = epa_pkg::STEP_SEL_ONE;
        end else if (phase == 1) begin
          fe = 1'b1;
          ae = 1'b1;
          ss = epa_pkg::STEP_SEL_THOUSAND;
        end else begin
          fe = ($urandom_range(0, 3) != 0);
          ae = $urandom_range(0, 1);
          ss = ($urandom_range(0, 7) == 0) ? STEP_SEL_NONE : 2'($urandom_range(0, 2));
        end
        // The first random phase runs with no idling on either side.
        tx_gappy = (phase != 0) && $urandom_range(0, 1);
        rx_stall_on = (phase != 0) && $urandom_range(0, 1);
        apply_setup(fe, ae, ss);
        // Mostly runs of qualified edges in one direction, so that the values reach their
        // bounds; now and then a broken run of random edges with the other pin often high.
        // The budget counts every edge posted, qualified or not.
        budget = $urandom_range(40, 150);
        left = budget;
        while (left > 0) begin
          dir = $urandom_range(0, 1);
          run = $urandom_range(1, 30);
          noisy = ($urandom_range(0, 7) == 0);
          for (k = 0; k < run && left > 0; k++) begin
            if (noisy) begin
              dir = $urandom_range(0, 1);
              pin = $urandom_range(0, 1);
            end else begin
              pin = ($urandom_range(0, 9) == 0) ? PIN_HIGH : PIN_LOW;
            end
            post_edge(dir, pin);
            left--;
          end
        end
        // Pressure in odd phases: either a long receiver hold-off while edges keep coming, or the sender
        // pausing midway until every outstanding result has come back.
        if (phase % 4 == 1) begin
          do @(posedge clk); while (edge_backlog_q.size() > budget / 2);
          hold_reqs++;
        end else if (phase % 4 == 3) begin
          do @(posedge clk); while (edge_backlog_q.size() > budget / 2);
          pause_tx = 1'b1;
          drain();
          pause_tx = 1'b0;
        end
        qualified += budget;
      end
      phase++;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  // Watchdog: ends a run that hangs.
  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/epa_pkg.sv
rtl/core/epa_ctrl.sv
rtl/core/epa_dp.sv
rtl/core/encoder_parameter_adjuster.sv
tb/tb_top.sv
